### src/esr_pkg.sv
// Shared types, constants and helpers for the expression shift-reduce recognizer.
// No dependencies; imported by the top level and the testbench.
package esr_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int SYM_W       = 8;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int OUT_DEPTH_W = 9;

   localparam logic [SYM_W-1:0] SYM_E     = 8'h45;   // 'E'
   localparam logic [SYM_W-1:0] SYM_T     = 8'h54;   // 'T'
   localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;   // '+'
   localparam logic [SYM_W-1:0] SYM_OPEN  = 8'h28;   // '('
   localparam logic [SYM_W-1:0] SYM_CLOSE = 8'h29;   // ')'
   localparam logic [SYM_W-1:0] LOWER_A   = 8'h61;   // 'a'
   localparam logic [SYM_W-1:0] LOWER_Z   = 8'h7A;   // 'z'
   localparam logic [SYM_W-1:0] UPPER_A   = 8'h41;   // 'A'
   localparam logic [SYM_W-1:0] UPPER_Z   = 8'h5A;   // 'Z'

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_FILL_NEAR,
      ST_FILL_FAR
   } esr_state_type;

   // Letters other than the nonterminals E and T reduce to T.
   function automatic logic is_ident(input logic [SYM_W-1:0] c);
      logic letter;
      letter = (c inside {[LOWER_A:LOWER_Z], [UPPER_A:UPPER_Z]});
      return letter && (c != SYM_E) && (c != SYM_T);
   endfunction

endpackage

### src/esr_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module esr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/expression_shift_reduce_recognizer.sv
// Top level of the expression shift-reduce recognizer.
// Depends on esr_pkg and esr_ram.

// One character per transfer is pushed on a 256-entry symbol stack held in a RAM,
// with the top three entries mirrored in registers. A small sequencer then applies
// at most one reduction per cycle (E+T to E, (E) to T, identifier letter to T,
// T to E, in that priority) through one compare unit on those registers. An item
// passes through the push, any single-symbol reductions, any E+T or (E) reductions
// (each of which refills the top registers through the RAM read port in the
// ST_FILL_NEAR and ST_FILL_FAR states) and the hand-off of the result, which waits
// while an earlier result still holds the output register.
// The block takes a new item while the previous result still waits on rsp_ready.
// On an item with req_last set, rsp_accepted reports a stack of exactly one E and
// the stack is emptied; rsp_overflow is sticky until reset.
module expression_shift_reduce_recognizer
   import esr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SYM_W-1:0]       req_symbol,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_accepted,
   output logic                   rsp_overflow,
   output logic [OUT_DEPTH_W-1:0] rsp_depth
);

   esr_state_type state_ff, state_in;
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic overflow_ff, overflow_in;
   logic last_ff, last_in;
   logic [SYM_W-1:0] top0_ff, top0_in;   // entry depth-1
   logic [SYM_W-1:0] top1_ff, top1_in;   // entry depth-2
   logic [SYM_W-1:0] top2_ff, top2_in;   // entry depth-3
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_accepted_ff, rsp_accepted_in;
   logic rsp_overflow_ff, rsp_overflow_in;
   logic [OUT_DEPTH_W-1:0] rsp_depth_ff, rsp_depth_in;

   logic wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [SYM_W-1:0] wr_data, rd_data;
   logic [CNT_W-1:0] depth_m1, depth_m3, depth_m4;
   logic has_three, has_one, out_free;

   assign depth_m1  = depth_ff - CNT_W'(1);
   assign depth_m3  = depth_ff - CNT_W'(3);
   assign depth_m4  = depth_ff - CNT_W'(4);
   assign has_three = depth_ff >= CNT_W'(3);
   assign has_one   = depth_ff != '0;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   esr_ram #(
      .WIDTH(SYM_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in        = state_ff;
      depth_in        = depth_ff;
      overflow_in     = overflow_ff;
      last_in         = last_ff;
      top0_in         = top0_ff;
      top1_in         = top1_ff;
      top2_in         = top2_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_overflow_in = rsp_overflow_ff;
      rsp_depth_in    = rsp_depth_ff;
      wr_en           = 1'b0;
      wr_addr         = depth_ff[ADDR_W-1:0];
      wr_data         = req_symbol;
      rd_addr         = depth_m4[ADDR_W-1:0];
      req_ready       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               last_in = req_last;
               if (depth_ff != CNT_W'(STACK_DEPTH)) begin
                  wr_en    = 1'b1;
                  top0_in  = req_symbol;
                  top1_in  = top0_ff;
                  top2_in  = top1_ff;
                  depth_in = depth_ff + CNT_W'(1);
               end else begin
                  // drop the push, flag it
                  overflow_in = 1'b1;
               end
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (has_three && top2_ff == SYM_E && top1_ff == SYM_PLUS && top0_ff == SYM_T) begin
               wr_en    = 1'b1;
               wr_addr  = depth_m3[ADDR_W-1:0];
               wr_data  = SYM_E;
               top0_in  = SYM_E;
               depth_in = depth_ff - CNT_W'(2);
               state_in = ST_FILL_NEAR;
            end else if (has_three && top2_ff == SYM_OPEN && top1_ff == SYM_E
                         && top0_ff == SYM_CLOSE) begin
               wr_en    = 1'b1;
               wr_addr  = depth_m3[ADDR_W-1:0];
               wr_data  = SYM_T;
               top0_in  = SYM_T;
               depth_in = depth_ff - CNT_W'(2);
               state_in = ST_FILL_NEAR;
            end else if (has_one && is_ident(top0_ff)) begin
               wr_en   = 1'b1;
               wr_addr = depth_m1[ADDR_W-1:0];
               wr_data = SYM_T;
               top0_in = SYM_T;
            end else if (has_one && top0_ff == SYM_T) begin
               wr_en   = 1'b1;
               wr_addr = depth_m1[ADDR_W-1:0];
               wr_data = SYM_E;
               top0_in = SYM_E;
            end else if (out_free) begin
               // no rule applies: hand off the result, empty the stack on last
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = last_ff && depth_ff == CNT_W'(1) && top0_ff == SYM_E;
               rsp_overflow_in = overflow_ff;
               rsp_depth_in    = OUT_DEPTH_W'(depth_ff);
               if (last_ff) begin
                  depth_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_FILL_NEAR: begin
            // read of the new depth-2 entry was issued by the reduction
            top1_in  = rd_data;
            rd_addr  = depth_m3[ADDR_W-1:0];
            state_in = ST_FILL_FAR;
         end
         ST_FILL_FAR: begin
            top2_in  = rd_data;
            state_in = ST_REDUCE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff         <= last_in;
      top0_ff         <= top0_in;
      top1_ff         <= top1_in;
      top2_ff         <= top2_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_overflow_ff <= rsp_overflow_in;
      rsp_depth_ff    <= rsp_depth_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_overflow = rsp_overflow_ff;
   assign rsp_depth    = rsp_depth_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared without reset");

   a_accept_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_accepted_ff) |-> rsp_depth_ff == OUT_DEPTH_W'(1))
      else $error("acceptance reported with depth other than one");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE && state_in == ST_IDLE && last_ff) |=> depth_ff == '0)
      else $error("stack not emptied after last item");

endmodule

### tb/sv/tb_expression_shift_reduce_recognizer.sv
// Testbench for expression_shift_reduce_recognizer: directed strings, a full stack and random
// expressions, each result checked against a parse stack kept inside the bench.
// Depends on esr_pkg and the RTL top level.
module tb_expression_shift_reduce_recognizer;
   timeunit 1ns;
   timeprecision 1ps;
   import esr_pkg::*;

   typedef struct packed {
      logic                   accepted;
      logic                   overflow;
      logic [OUT_DEPTH_W-1:0] depth;
   } parse_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_valid  = 1'b0;
   logic                   req_ready;
   logic [SYM_W-1:0]       req_symbol = '0;
   logic                   req_last   = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready  = 1'b0;
   logic                   rsp_accepted;
   logic                   rsp_overflow;
   logic [OUT_DEPTH_W-1:0] rsp_depth;

   // Parse stack mirror, updated once per accepted transfer
   logic [SYM_W-1:0] model_stack [STACK_DEPTH];
   int unsigned      model_depth    = 0;
   logic             model_overflow = 1'b0;

   parse_result_type pending_results[$];
   logic [SYM_W-1:0] sentence_q[$];
   int               items_sent     = 0;
   int               mismatch_count = 0;
   int               hold_off_left  = 0;
   logic             idle_on        = 1'b1;

   expression_shift_reduce_recognizer u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_symbol   (req_symbol),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_accepted (rsp_accepted),
      .rsp_overflow (rsp_overflow),
      .rsp_depth    (rsp_depth)
   );

   always #2 clock = ~clock;

   function automatic parse_result_type predict_symbol(input logic [SYM_W-1:0] sym,
                                                       input logic last);
      parse_result_type res;
      logic [SYM_W-1:0] top;
      int unsigned      d;
      int               guard;
      logic             changed;
      if (model_depth < STACK_DEPTH) begin
         model_stack[model_depth] = sym;
         model_depth++;
      end else begin
         model_overflow = 1'b1;
      end
      guard = 0;
      do begin
         d = model_depth;
         top = (d >= 1) ? model_stack[d-1] : '0;
         changed = 1'b1;
         if (d >= 3 && model_stack[d-3] == SYM_E && model_stack[d-2] == SYM_PLUS &&
             top == SYM_T) begin
            model_depth = d - 2;
         end else if (d >= 3 && model_stack[d-3] == SYM_OPEN && model_stack[d-2] == SYM_E &&
                      top == SYM_CLOSE) begin
            model_stack[d-3] = SYM_T;
            model_depth = d - 2;
         end else if (d >= 1 && ((top >= LOWER_A && top <= LOWER_Z) ||
                                 (top >= UPPER_A && top <= UPPER_Z)) &&
                      top != SYM_E && top != SYM_T) begin
            model_stack[d-1] = SYM_T;
         end else if (d >= 1 && top == SYM_T) begin
            model_stack[d-1] = SYM_E;
         end else begin
            changed = 1'b0;
         end
         guard++;
      end while (changed && guard < 4 * STACK_DEPTH);
      res.overflow = model_overflow;
      res.depth    = model_depth[OUT_DEPTH_W-1:0];
      res.accepted = last && model_depth == 1 && model_stack[0] == SYM_E;
      if (last) begin
         model_depth = 0;
      end
      return res;
   endfunction

   // Mostly identifier letters, now and then a nonterminal letter
   function automatic logic [SYM_W-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return SYM_E;
         1: return SYM_T;
         2, 3, 4, 5: return 8'(LOWER_A + $urandom_range(0, 25));
         default: return 8'(UPPER_A + $urandom_range(0, 25));
      endcase
   endfunction

   task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_symbol <= sym;
      req_last   <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_results.push_back(predict_symbol(sym, last));
      items_sent++;
   endtask

   task automatic send_text(input string text);
      for (int k = 0; k < text.len(); k++) begin
         send_symbol(text[k], k == text.len() - 1);
      end
   endtask

   // Append a well-formed expression with random operands and nesting
   task automatic gen_expr(input int level);
      int terms;
      terms = $urandom_range(1, 3);
      for (int k = 0; k < terms; k++) begin
         if (k > 0) begin
            sentence_q.push_back(SYM_PLUS);
         end
         if (level < 3 && $urandom_range(0, 3) == 0) begin
            sentence_q.push_back(SYM_OPEN);
            gen_expr(level + 1);
            sentence_q.push_back(SYM_CLOSE);
         end else begin
            sentence_q.push_back(pick_operand());
         end
      end
   endtask

   task automatic test_single_symbols();
      logic [SYM_W-1:0] probe [12];
      probe = '{LOWER_A, LOWER_Z, UPPER_A, UPPER_Z, SYM_E, SYM_T,
                8'h40, 8'h5B, 8'h60, 8'h7B, 8'hFF, 8'h00};
      foreach (probe[k]) begin
         send_symbol(probe[k], 1'b1);
      end
   endtask

   task automatic test_grammar_rules();
      send_text("a+b");
      send_text("E+T");
      send_text("(a+b)+c");
   endtask

   task automatic test_random_expressions(input int target);
      int               pick;
      int               pos;
      logic             keep_open;
      logic [SYM_W-1:0] sym;
      while (items_sent < target) begin
         sentence_q.delete();
         pick = $urandom_range(0, 19);
         if (pick < 17) begin
            gen_expr(0);
         end else begin
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 4))
                  0: sym = SYM_PLUS;
                  1: sym = SYM_OPEN;
                  2: sym = SYM_CLOSE;
                  3: sym = pick_operand();
                  default: sym = 8'($urandom_range(1, 255));
               endcase
               sentence_q.push_back(sym);
            end
         end
         // break some of the well-formed strings
         if (pick >= 13 && pick < 17) begin
            pos = $urandom_range(0, sentence_q.size() - 1);
            case ($urandom_range(0, 2))
               0: sentence_q[pos] = 8'($urandom_range(1, 255));
               1: if (sentence_q.size() > 1) sentence_q.delete(pos);
               default: sentence_q.insert(pos, ($urandom_range(0, 1) != 0) ?
                                               SYM_OPEN : SYM_CLOSE);
            endcase
         end
         // leave the string open now and then so the stack carries into the next one
         keep_open = ($urandom_range(0, 19) == 0);
         foreach (sentence_q[k]) begin
            send_symbol(sentence_q[k], (k == sentence_q.size() - 1) && !keep_open);
         end
      end
   endtask

   task automatic test_output_backpressure();
      hold_off_left = 80;
      test_random_expressions(items_sent + 40);
   endtask

   task automatic test_stack_overflow();
      repeat (STACK_DEPTH + 3) send_symbol(SYM_OPEN, 1'b0);
      send_symbol(LOWER_A, 1'b0);
      send_symbol(SYM_CLOSE, 1'b1);
   endtask

   initial begin : rsp_ready_driver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      parse_result_type got;
      parse_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got = {rsp_accepted, rsp_overflow, rsp_depth};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result: accepted=%0b overflow=%0b depth=%0d",
                        got.accepted, got.overflow, got.depth);
            end
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display({"mismatch at %0t: expected accepted=%0b overflow=%0b depth=%0d,",
                            " got accepted=%0b overflow=%0b depth=%0d"},
                           $realtime, want.accepted, want.overflow, want.depth,
                           got.accepted, got.overflow, got.depth);
               end
            end
         end
      end
   end

   initial begin : watchdog
      #2ms;
      $display("TB_ERROR");
      $finish;
   end

   initial begin : main_sequence
      int waited;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_single_symbols();
      test_grammar_rules();
      test_random_expressions(700);
      test_output_backpressure();
      test_stack_overflow();
      idle_on = 1'b0;
      test_random_expressions(1200);
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      // drain: let any stray result show up
      repeat (20) @(posedge clock);
      if (pending_results.size() != 0) begin
         mismatch_count += pending_results.size();
         $display("%0d results never arrived", pending_results.size());
      end
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
